[design/dsfg_pkg.sv]
package dsfg_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int W  = 52;   // CORDIC x/y datapath, mm * 2^30 with growth
    localparam int ZW = 27;   // CORDIC angle, degrees * 65536

    localparam logic signed [ZW-1:0] QUARTER_Z = ZW'(5898240);
    localparam logic signed [ZW-1:0] HALF_Z    = ZW'(11796480);
    localparam logic signed [W-1:0]  GAIN_Q30  = W'(652032875);

    localparam logic signed [17:0] FULL_TURN = 18'sd23040;
    localparam logic signed [16:0] HALF_TURN = 17'sd11520;
    localparam logic signed [17:0] ALT_LIMIT = 18'sd17280;
    localparam logic signed [16:0] RIGHT_ANG = 17'sd5760;

    // configuration register indexes
    localparam logic [2:0] CFG_AZ_OFF  = 3'd0;
    localparam logic [2:0] CFG_ALT_OFF = 3'd1;
    localparam logic [2:0] CFG_RADIUS  = 3'd2;
    localparam logic [2:0] CFG_HEIGHT  = 3'd3;
    localparam logic [2:0] CFG_TOL     = 3'd4;

    typedef struct packed {
        logic start;
        logic vec;    // 1: vectoring, 0: rotation
    } t_cordic_cmd;

    typedef struct packed {
        logic start;
        logic ack;
    } t_seq_ctl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_seq_sts;

    function automatic logic signed [ZW-1:0] atan_z(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:  v = ZW'(2949120);
            5'd1:  v = ZW'(1740967);
            5'd2:  v = ZW'(919879);
            5'd3:  v = ZW'(466945);
            5'd4:  v = ZW'(234379);
            5'd5:  v = ZW'(117304);
            5'd6:  v = ZW'(58666);
            5'd7:  v = ZW'(29335);
            5'd8:  v = ZW'(14668);
            5'd9:  v = ZW'(7334);
            5'd10: v = ZW'(3667);
            5'd11: v = ZW'(1833);
            5'd12: v = ZW'(917);
            5'd13: v = ZW'(458);
            5'd14: v = ZW'(229);
            5'd15: v = ZW'(115);
            5'd16: v = ZW'(57);
            5'd17: v = ZW'(29);
            5'd18: v = ZW'(14);
            5'd19: v = ZW'(7);
            5'd20: v = ZW'(4);
            5'd21: v = ZW'(2);
            5'd22: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // degrees*65536 -> degrees*64, rounded half up
    function automatic logic signed [ZW-11:0] to_deg64(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] t;
        t = z + ZW'(512);
        return t[ZW-1:10];
    endfunction

endpackage

[design/dsfg_cordic.sv]
module dsfg_cordic (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dsfg_pkg::t_cordic_cmd            i_cmd,
    input  logic signed [dsfg_pkg::W-1:0]    i_x,
    input  logic signed [dsfg_pkg::W-1:0]    i_y,
    input  logic signed [dsfg_pkg::ZW-1:0]   i_z,
    output logic signed [dsfg_pkg::W-1:0]    o_x,
    output logic signed [dsfg_pkg::W-1:0]    o_y,
    output logic signed [dsfg_pkg::ZW-1:0]   o_z,
    output logic                             o_done
);

    logic signed [dsfg_pkg::W-1:0]  r_x, r_y, n_x, n_y, xs, ys;
    logic signed [dsfg_pkg::ZW-1:0] r_z, n_z, ang;
    logic [dsfg_pkg::STEP_W-1:0]    r_i;
    logic                           r_busy, r_done, r_vec, sigma;

    always_comb begin
        xs  = r_x >>> r_i;
        ys  = r_y >>> r_i;
        ang = dsfg_pkg::atan_z(5'(r_i));
        // sigma=1: x -= y>>i, y += x>>i, z -= atan
        sigma = r_vec ? r_y[dsfg_pkg::W-1] : !r_z[dsfg_pkg::ZW-1];
        if (sigma) begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - ang;
        end else begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == dsfg_pkg::STEP_W'(dsfg_pkg::CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_z   <= i_z;
            r_vec <= i_cmd.vec;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_done = r_done;

endmodule

[design/dsfg_seq.sv]
module dsfg_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dsfg_pkg::t_seq_ctl  i_ctl,
    output dsfg_pkg::t_seq_sts  o_sts,
    input  logic [14:0]         i_az,
    input  logic signed [13:0]  i_alt,
    input  logic [15:0]         i_radius,
    input  logic signed [16:0]  i_height,
    input  logic signed [14:0]  i_az_off,
    input  logic signed [14:0]  i_alt_off,
    output logic [14:0]         o_req_az,
    output logic signed [15:0]  o_calt
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ROT  = 4'd1;
    localparam logic [3:0] S_M0   = 4'd2;
    localparam logic [3:0] S_M1   = 4'd3;
    localparam logic [3:0] S_M2   = 4'd4;
    localparam logic [3:0] S_V1   = 4'd5;
    localparam logic [3:0] S_W1   = 4'd6;
    localparam logic [3:0] S_V2   = 4'd7;
    localparam logic [3:0] S_W2   = 4'd8;
    localparam logic [3:0] S_SUM  = 4'd9;
    localparam logic [3:0] S_WRAP = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    localparam int W  = dsfg_pkg::W;
    localparam int ZW = dsfg_pkg::ZW;

    logic [3:0] r_state, n_state;

    dsfg_pkg::t_cordic_cmd    cmd;
    logic signed [W-1:0]      c_x0, c_y0, c_ox, c_oy;
    logic signed [ZW-1:0]     c_z0, c_oz;
    logic                     c_done;

    logic signed [ZW-1:0]     z_alt;
    logic signed [W-1:0]      r_c, r_s, r_gy, r_n, r_hc, r_d, geo_x, d_sum;
    logic signed [ZW-1:0]     r_qadd;
    logic                     r_neg;
    logic signed [16:0]       r_geo, r_slit;
    logic signed [17:0]       r_acc, calt_sum;
    logic signed [15:0]       r_calt;

    logic signed [16:0]       mul_a;
    logic signed [33:0]       mul_b;
    logic signed [50:0]       mul_p;

    dsfg_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_x     (c_x0),
        .i_y     (c_y0),
        .i_z     (c_z0),
        .o_x     (c_ox),
        .o_y     (c_oy),
        .o_z     (c_oz),
        .o_done  (c_done)
    );

    always_comb begin
        z_alt = ZW'(i_alt) <<< 10;
        geo_x = (W'(i_height) <<< 30) + r_n;
        d_sum = r_hc + r_gy;
        calt_sum = 18'(i_alt) + 18'(i_alt_off) + 18'(r_slit);
    end

    // shared multiplier
    always_comb begin
        mul_a = $signed({1'b0, i_radius});
        mul_b = r_s[33:0];
        case (r_state)
            S_M1:    mul_b = r_c[33:0];
            S_M2: begin
                mul_a = i_height;
                mul_b = r_c[33:0];
            end
            default: mul_b = r_s[33:0];
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        n_state   = r_state;
        cmd.start = 1'b0;
        cmd.vec   = 1'b0;
        c_x0      = dsfg_pkg::GAIN_Q30;
        c_y0      = '0;
        c_z0      = z_alt;
        if (z_alt > dsfg_pkg::QUARTER_Z)
            c_z0 = z_alt - dsfg_pkg::HALF_Z;
        else if (z_alt < -dsfg_pkg::QUARTER_Z)
            c_z0 = z_alt + dsfg_pkg::HALF_Z;
        unique case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    if (i_radius == '0) begin
                        n_state = S_SUM;
                    end else begin
                        cmd.start = 1'b1;
                        n_state   = S_ROT;
                    end
                end
            end
            S_ROT:  if (c_done) n_state = S_M0;
            S_M0:   n_state = S_M1;
            S_M1:   n_state = S_M2;
            S_M2:   n_state = S_V1;
            S_V1: begin
                cmd.start = 1'b1;
                cmd.vec   = 1'b1;
                c_z0      = '0;
                c_x0      = geo_x[W-1] ? -geo_x : geo_x;
                c_y0      = geo_x[W-1] ? -r_gy : r_gy;
                n_state   = S_W1;
            end
            S_W1:   if (c_done) n_state = S_V2;
            S_V2: begin
                c_z0 = '0;
                if (r_d == '0) begin
                    n_state = S_SUM;
                end else begin
                    cmd.start = 1'b1;
                    cmd.vec   = 1'b1;
                    c_x0      = r_d[W-1] ? -r_d : r_d;
                    c_y0      = r_d[W-1] ? -r_n : r_n;
                    n_state   = S_W2;
                end
            end
            S_W2:   if (c_done) n_state = S_SUM;
            S_SUM:  n_state = S_WRAP;
            S_WRAP: begin
                if (!r_acc[17] && r_acc < dsfg_pkg::FULL_TURN) n_state = S_DONE;
            end
            S_DONE: if (i_ctl.ack) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_neg  <= (z_alt > dsfg_pkg::QUARTER_Z) || (z_alt < -dsfg_pkg::QUARTER_Z);
                r_geo  <= '0;
                r_slit <= '0;
            end
            S_ROT: begin
                if (c_done) begin
                    r_c <= r_neg ? -c_ox : c_ox;
                    r_s <= r_neg ? -c_oy : c_oy;
                end
            end
            S_M0: r_gy <= W'(mul_p);
            S_M1: r_n  <= W'(mul_p);
            S_M2: r_hc <= W'(mul_p);
            S_V1: begin
                r_d    <= d_sum;
                r_qadd <= !geo_x[W-1] ? '0 :
                          (r_gy[W-1] ? -dsfg_pkg::HALF_Z : dsfg_pkg::HALF_Z);
            end
            S_W1: if (c_done) r_geo <= dsfg_pkg::to_deg64(c_oz + r_qadd);
            S_V2: begin
                if (r_d == '0)
                    r_slit <= r_n[W-1] ? -dsfg_pkg::RIGHT_ANG : dsfg_pkg::RIGHT_ANG;
            end
            S_W2: if (c_done) r_slit <= dsfg_pkg::to_deg64(c_oz);
            S_SUM: begin
                r_acc <= $signed({3'b000, i_az}) + 18'(i_az_off) + 18'(r_geo);
                if (calt_sum > dsfg_pkg::ALT_LIMIT)
                    r_calt <= 16'(dsfg_pkg::ALT_LIMIT);
                else if (calt_sum < -dsfg_pkg::ALT_LIMIT)
                    r_calt <= 16'(-dsfg_pkg::ALT_LIMIT);
                else
                    r_calt <= calt_sum[15:0];
            end
            S_WRAP: begin
                if (r_acc[17])                          r_acc <= r_acc + dsfg_pkg::FULL_TURN;
                else if (r_acc >= dsfg_pkg::FULL_TURN)  r_acc <= r_acc - dsfg_pkg::FULL_TURN;
            end
            default: ;
        endcase
    end

    assign o_sts.idle = (r_state == S_IDLE);
    assign o_sts.done = (r_state == S_DONE);
    assign o_req_az   = r_acc[14:0];
    assign o_calt     = r_calt;

endmodule

[design/dome_slit_follow_geometry_top.sv]
// Dome slit follow geometry. Each request (mode 0: new telescope position,
// stored only while following; mode 1: poll with the stored position) yields
// one result: required dome azimuth, corrected slit altitude, wrapped slit
// offset, in-slit flag, move request and a rejected flag. Angles are degrees
// times 64. With a nonzero radius a request runs a single shared CORDIC
// stage for CORDIC_STEPS iterations up to three times (sin/cos of the
// altitude, the azimuth atan2 and, if its denominator is nonzero, the slit
// arctangent), plus three passes of one shared multiplier and the wrap steps;
// with radius 0 only the sum and wrap steps run. o_s_tready is low from
// acceptance until the result is handed to the output register; the output
// register lets the next request enter while a result waits. Configuration
// writes complete every cycle and are meant for idle periods only.
module dome_slit_follow_geometry_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [0] following, [15:1] telescope_az, [29:16] telescope_alt,
    // [44:30] dome_az, [45] dome_az_valid
    input  logic [47:0] i_s_tdata,
    // [0] mode
    input  logic [0:0]  i_s_tuser,
    // result channel
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [14:0] required_az, [30:15] corrected_alt, [45:31] slit_offset,
    // [46] in_slit, [47] move_request, [48] rejected
    output logic [55:0] o_m_tdata,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    logic signed [14:0] r_az_off, r_alt_off;
    logic [15:0]        r_radius;
    logic signed [16:0] r_height;
    logic [13:0]        r_tol;

    logic [14:0]        r_st_az;
    logic signed [13:0] r_st_alt;

    logic               r_go, r_mode, r_fol, r_dvalid;
    logic [14:0]        r_daz;

    dsfg_pkg::t_seq_ctl ctl;
    dsfg_pkg::t_seq_sts sts;
    logic [14:0]        req_az;
    logic signed [15:0] calt;

    logic               accept, load;
    logic signed [16:0] diff, off;
    logic [16:0]        mag, raw_mag;
    logic               in_slit, move;

    logic               r_m_valid;
    logic [14:0]        r_req;
    logic signed [15:0] r_calt;
    logic signed [14:0] r_off;
    logic               r_in_slit, r_move, r_rej;

    assign accept      = i_s_tvalid && o_s_tready;
    assign o_s_tready  = sts.idle && !r_go;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_az_off  <= '0;
            r_alt_off <= '0;
            r_radius  <= '0;
            r_height  <= '0;
            r_tol     <= 14'd64;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dsfg_pkg::CFG_AZ_OFF:  r_az_off  <= i_cfg_data[14:0];
                dsfg_pkg::CFG_ALT_OFF: r_alt_off <= i_cfg_data[14:0];
                dsfg_pkg::CFG_RADIUS:  r_radius  <= i_cfg_data[15:0];
                dsfg_pkg::CFG_HEIGHT:  r_height  <= i_cfg_data;
                dsfg_pkg::CFG_TOL:     r_tol     <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // stored telescope position and request capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_az  <= '0;
            r_st_alt <= '0;
            r_go     <= 1'b0;
        end else begin
            r_go <= accept;
            if (accept && !i_s_tuser[0] && i_s_tdata[0]) begin
                r_st_az  <= i_s_tdata[15:1];
                r_st_alt <= i_s_tdata[29:16];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= i_s_tuser[0];
            r_fol    <= i_s_tdata[0];
            r_daz    <= i_s_tdata[44:30];
            r_dvalid <= i_s_tdata[45];
        end
    end

    assign ctl.start = r_go;
    assign ctl.ack   = load;

    dsfg_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .o_sts     (sts),
        .i_az      (r_st_az),
        .i_alt     (r_st_alt),
        .i_radius  (r_radius),
        .i_height  (r_height),
        .i_az_off  (r_az_off),
        .i_alt_off (r_alt_off),
        .o_req_az  (req_az),
        .o_calt    (calt)
    );

    // slit offset, in-slit test and move decision
    always_comb begin
        diff = $signed({2'b00, r_daz}) - $signed({2'b00, req_az});
        off  = diff;
        if (diff > dsfg_pkg::HALF_TURN)       off = diff - 17'sd23040;
        else if (diff < -dsfg_pkg::HALF_TURN) off = diff + 17'sd23040;
        mag     = off[16] ? 17'(-off) : 17'(off);
        raw_mag = diff[16] ? 17'(-diff) : 17'(diff);
        in_slit = r_dvalid && (mag <= {3'b000, r_tol});
        if (!r_mode)
            move = r_fol && r_dvalid && (raw_mag > {3'b000, r_tol});
        else
            move = r_fol && !in_slit;
    end

    assign load = sts.done && (!r_m_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_req     <= req_az;
            r_calt    <= calt;
            r_off     <= r_dvalid ? off[14:0] : '0;
            r_in_slit <= in_slit;
            r_move    <= move;
            r_rej     <= !r_mode && !r_fol;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {7'b0, r_rej, r_move, r_in_slit, r_off, r_calt, r_req};

    // a rejected request never asks for a move
    a_rej_no_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> !(r_rej && r_move))
        else $error("rejected request with move");

    // slit altitude stays saturated
    a_calt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> (r_calt <= 16'sd17280 && r_calt >= -16'sd17280))
        else $error("corrected altitude out of range");

    // required azimuth is wrapped to one turn
    a_req_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> (r_req < 15'd23040))
        else $error("required azimuth not wrapped");

    // no new request is taken right after one is accepted
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_tready)
        else $error("ready while busy");

endmodule
